FILE: rtl/core/obstacle_baseline_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Obstacle baseline tracker assertion macros
// Concurrent check wrappers used by the assertions in the tracker top.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_BASELINE_TRACKER_TOP_DEFINES_SVH
`define OBSTACLE_BASELINE_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define OBT_ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("obt check failed");

// next-cycle implication
`define OBT_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("obt check failed");

`endif

FILE: rtl/core/obt_pkg.sv
// ----------------------------------------------------------------------------
// Obstacle baseline tracker package
// Payload types, configuration record, register indexes and constants.
// ----------------------------------------------------------------------------
package obt_pkg;

  localparam int FIELD_W   = 16;
  localparam int NUM_CH    = 3;
  localparam int CH_W      = 2;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TRIGGER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_TRIGGER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TRIGGER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_COUNT  = 3'd4;

  localparam int BASE_LIMIT   = 2000;
  localparam int STRAY_LIMIT  = 50;
  localparam int RESET_LEVEL  = 100;
  localparam int ADJUST_RESET = 20;
  localparam int LEVEL_MIN    = -(2 ** (FIELD_W - 1));

  typedef struct packed {
    logic signed [FIELD_W-1:0] raw_left;
    logic signed [FIELD_W-1:0] raw_front;
    logic signed [FIELD_W-1:0] raw_right;
    logic                      do_adjust;
    logic signed [FIELD_W-1:0] left_margin;
    logic signed [FIELD_W-1:0] front_margin;
    logic signed [FIELD_W-1:0] right_margin;
  } obt_in_t;

  typedef struct packed {
    logic                      left_blocked;
    logic                      front_blocked;
    logic                      right_blocked;
    logic                      front_over;
    logic signed [FIELD_W-1:0] left_level;
    logic signed [FIELD_W-1:0] front_level;
    logic signed [FIELD_W-1:0] right_level;
  } obt_out_t;

  typedef struct packed {
    logic                      enabled;
    logic signed [FIELD_W-1:0] left_trigger;
    logic signed [FIELD_W-1:0] front_trigger;
    logic signed [FIELD_W-1:0] right_trigger;
    logic [FIELD_W-1:0]        adjust_count;
  } obt_cfg_t;

endpackage

FILE: rtl/core/obt_div.sv
// ----------------------------------------------------------------------------
// Obstacle baseline tracker serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module obt_div import obt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    shifted;
  logic              ge;

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        // remainder stays below the divisor, so it fits CNT_W bits
        rem_r  <= ge ? CNT_W'(shifted - {1'b0, dvs_r}) : shifted[CNT_W-1:0];
        quo_r  <= {quo_r[SUM_W-2:0], ge};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/obt_cfg.sv
// ----------------------------------------------------------------------------
// Obstacle baseline tracker configuration registers
// Holds enable, triggers and adjust count; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module obt_cfg import obt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [FIELD_W-1:0]   wr_data,
  output obt_cfg_t             regs
);

  obt_cfg_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.enabled       <= 1'b0;
      regs_r.left_trigger  <= FIELD_W'(RESET_LEVEL);
      regs_r.front_trigger <= FIELD_W'(RESET_LEVEL);
      regs_r.right_trigger <= FIELD_W'(RESET_LEVEL);
      regs_r.adjust_count  <= FIELD_W'(ADJUST_RESET);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENABLED:       regs_r.enabled       <= wr_data[0];
        REG_LEFT_TRIGGER:  regs_r.left_trigger  <= wr_data;
        REG_FRONT_TRIGGER: regs_r.front_trigger <= wr_data;
        REG_RIGHT_TRIGGER: regs_r.right_trigger <= wr_data;
        REG_ADJUST_COUNT:  regs_r.adjust_count  <= wr_data;
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

FILE: rtl/core/obstacle_baseline_tracker_top.sv
// ----------------------------------------------------------------------------
// Obstacle baseline tracker
// Baseline-compensated obstacle levels, blocked flags and baseline tracking.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  in        in_valid / in_ready / in_data           item in
//  out       out_valid / out_ready / out_data        result out
//  cfg       cfg_valid / cfg_ready / cfg_index/data  register write in
//
// Without do_adjust an item goes from idle straight to the finish step; with
// it, per channel an accumulate step, a wait on the shared serial divider
// (one quotient bit a cycle) and an update step, three channels in turn.
// Synchronous active-low reset; no clearing pass. in_ready and cfg_ready are
// low while an item is at work; a finished result waits in the output register.
// ----------------------------------------------------------------------------
`include "obstacle_baseline_tracker_top_defines.svh"

module obstacle_baseline_tracker_top import obt_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  obt_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output obt_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  localparam int LVL_W = FIELD_W + 1;

  typedef enum logic [2:0] {ST_IDLE, ST_ACC, ST_DIV, ST_UPD, ST_FIN} state_t;

  state_t                    state_r;
  logic [CH_W-1:0]           ch_r;
  logic signed [FIELD_W-1:0] lvl_r  [NUM_CH];
  logic signed [FIELD_W-1:0] base_r [NUM_CH];
  logic signed [FIELD_W-1:0] off_r  [NUM_CH];
  logic signed [SUM_W-1:0]   sum_r  [NUM_CH];
  logic [CNT_W-1:0]          cnt_r  [NUM_CH];
  logic                      neg_r;
  logic signed [SUM_W-1:0]   avg_r;
  obt_out_t                  out_r;
  logic                      out_valid_r;

  obt_cfg_t cfg;

  // accept-time lanes
  logic signed [FIELD_W-1:0] raw_in  [NUM_CH];
  logic signed [FIELD_W-1:0] offs_in [NUM_CH];
  logic signed [LVL_W-1:0]   diff_in [NUM_CH];
  logic signed [FIELD_W-1:0] lvl_in  [NUM_CH];

  // shared datapath
  logic                      wrap;
  logic signed [SUM_W-1:0]   acc_sum;
  logic [CNT_W-1:0]          acc_cnt;
  logic [SUM_W-1:0]          acc_mag;
  logic                      div_start;
  logic                      div_done;
  logic [SUM_W-1:0]          div_q;
  logic signed [SUM_W:0]     stray_diff;
  logic                      stray;
  logic                      due;
  logic signed [SUM_W-1:0]   avg_adj;
  logic signed [SUM_W-1:0]   half;
  logic signed [SUM_W-1:0]   nb;
  logic signed [FIELD_W-1:0] new_base;

  // result flags
  logic signed [FIELD_W-1:0] trig [NUM_CH];
  logic signed [LVL_W-1:0]   thr  [NUM_CH];
  logic [NUM_CH-1:0]         blk;
  logic                      front_over;

  // checker terms
  logic                      base_ok;
  logic                      window_ok;

  obt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  assign div_start = (state_r == ST_ACC);

  obt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_mag),
    .divisor  (acc_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    raw_in[0]  = in_data.raw_left;
    raw_in[1]  = in_data.raw_front;
    raw_in[2]  = in_data.raw_right;
    offs_in[0] = in_data.left_margin;
    offs_in[1] = in_data.front_margin;
    offs_in[2] = in_data.right_margin;
    for (int i = 0; i < NUM_CH; i++) begin
      diff_in[i] = {{(LVL_W - SAMPLE_WIDTH){raw_in[i][SAMPLE_WIDTH-1]}},
                    raw_in[i][SAMPLE_WIDTH-1:0]}
                   - {base_r[i][FIELD_W-1], base_r[i]};
      // saturate when the two top bits disagree
      if (diff_in[i][LVL_W-1] != diff_in[i][FIELD_W-1]) begin
        lvl_in[i] = diff_in[i][LVL_W-1] ? {1'b1, {(FIELD_W-1){1'b0}}}
                                        : {1'b0, {(FIELD_W-1){1'b1}}};
      end else begin
        lvl_in[i] = diff_in[i][FIELD_W-1:0];
      end
    end
  end

  // accumulate step; a full count starts a new window first
  always_comb begin
    wrap    = (cnt_r[ch_r] == '1);
    acc_sum = (wrap ? SUM_W'(0) : sum_r[ch_r]) + SUM_W'(lvl_r[ch_r]);
    acc_cnt = (wrap ? CNT_W'(0) : cnt_r[ch_r]) + 1'b1;
    acc_mag = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : acc_sum;
  end

  // stray check and baseline update
  always_comb begin
    stray_diff = (SUM_W + 1)'(avg_r) - (SUM_W + 1)'(lvl_r[ch_r]);
    stray      = (stray_diff > STRAY_LIMIT) || (stray_diff < -STRAY_LIMIT);
    due        = cnt_r[ch_r] > cfg.adjust_count;
    // halve toward zero
    avg_adj    = avg_r + $signed({{(SUM_W-1){1'b0}}, avg_r[SUM_W-1]});
    half       = avg_adj >>> 1;
    nb         = half + SUM_W'(base_r[ch_r]);
    if (nb > BASE_LIMIT) begin
      new_base = FIELD_W'(BASE_LIMIT);
    end else if (nb < LEVEL_MIN) begin
      new_base = FIELD_W'(LEVEL_MIN);
    end else begin
      new_base = nb[FIELD_W-1:0];
    end
  end

  always_comb begin
    trig[0] = $signed(cfg.left_trigger);
    trig[1] = $signed(cfg.front_trigger);
    trig[2] = $signed(cfg.right_trigger);
    for (int i = 0; i < NUM_CH; i++) begin
      thr[i] = LVL_W'(trig[i]) + LVL_W'(off_r[i]);
      blk[i] = cfg.enabled && (LVL_W'(lvl_r[i]) > thr[i]);
    end
    front_over = lvl_r[1] > trig[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        lvl_r[i]  <= '0;
        base_r[i] <= FIELD_W'(RESET_LEVEL);
        sum_r[i]  <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      // in ST_FIN the output register is reloaded or kept instead
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < NUM_CH; i++) begin
              lvl_r[i] <= lvl_in[i];
              off_r[i] <= offs_in[i];
            end
            ch_r    <= '0;
            state_r <= in_data.do_adjust ? ST_ACC : ST_FIN;
          end
        end
        ST_ACC: begin
          sum_r[ch_r] <= acc_sum;
          cnt_r[ch_r] <= acc_cnt;
          neg_r       <= acc_sum[SUM_W-1];
          state_r     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            avg_r   <= neg_r ? -$signed(div_q) : $signed(div_q);
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (stray || due) begin
            sum_r[ch_r] <= '0;
            cnt_r[ch_r] <= '0;
          end
          if (!stray && due) begin
            base_r[ch_r] <= new_base;
          end
          if (ch_r == CH_W'(NUM_CH - 1)) begin
            state_r <= ST_FIN;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= ST_ACC;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_r.left_blocked  <= blk[0];
            out_r.front_blocked <= blk[1];
            out_r.right_blocked <= blk[2];
            out_r.front_over    <= front_over;
            out_r.left_level    <= lvl_r[0];
            out_r.front_level   <= lvl_r[1];
            out_r.right_level   <= lvl_r[2];
            out_valid_r         <= 1'b1;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = (state_r == ST_IDLE);

  assign base_ok   = (base_r[0] <= BASE_LIMIT) && (base_r[1] <= BASE_LIMIT)
                     && (base_r[2] <= BASE_LIMIT);
  assign window_ok = (cnt_r[0] != '0 || sum_r[0] == '0) && (cnt_r[1] != '0 || sum_r[1] == '0)
                     && (cnt_r[2] != '0 || sum_r[2] == '0);

  `OBT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `OBT_ASSERT_IMPL(a_div_done_in_wait, clk, rst_n, div_done, state_r == ST_DIV)
  `OBT_ASSERT_IMPL(a_base_capped, clk, rst_n, 1'b1, base_ok)
  `OBT_ASSERT_IMPL(a_empty_window, clk, rst_n, 1'b1, window_ok)

endmodule
